// ===== hdl/udpic_pkg.sv =====
// udpic_pkg: types and constants of the up/down prescaled interrupt counter
// used by udpic_step, by the top level and by the bench; depends on nothing else

package udpic_pkg;

    // register indexes of a register-write word
    localparam logic [2:0] REG_ENABLE_BIT = 3'd0;
    localparam logic [2:0] REG_MODE       = 3'd1;
    localparam logic [2:0] REG_DISABLE    = 3'd2;
    localparam logic [2:0] REG_ENABLE     = 3'd3;
    localparam logic [2:0] REG_PRESCALE   = 3'd4;
    localparam logic [2:0] REG_COUNT      = 3'd5;
    localparam logic [2:0] REG_FLIP       = 3'd6;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // direction field, mode bits 7:6
    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b10;

    localparam logic [7:0] SCALE_NARROW = 8'h07;
    localparam logic [7:0] SCALE_WIDE   = 8'hFF;
    localparam logic [7:0] COUNT_ZERO   = 8'h00;

    typedef struct packed {
        logic       enabled;
        logic [7:0] mode;
        logic [7:0] prescale;
        logic [7:0] count;
        logic [7:0] flip;
        logic       pending;
    } udpic_state_t;

    typedef struct packed {
        logic       action;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [1:0] tick_source;
    } udpic_word_t;

endpackage

// ===== hdl/udpic_step.sv =====
// udpic_step: next counter state for one input word (write or tick)
// pure combinational logic; depends on udpic_pkg

module udpic_step
(
    input  udpic_pkg::udpic_word_t  word,
    input  udpic_pkg::udpic_state_t cur,
    output udpic_pkg::udpic_state_t nxt
);

    logic [7:0] mask;
    logic [7:0] pre_up;
    logic [7:0] pre_down;
    logic [7:0] cnt_up;
    logic       hit;

    assign mask     = cur.mode[2] ? udpic_pkg::SCALE_NARROW : udpic_pkg::SCALE_WIDE;
    assign pre_up   = cur.prescale + 8'd1;
    assign pre_down = cur.prescale - 8'd1;
    assign cnt_up   = cur.count + 8'd1;
    assign hit      = cur.enabled && (cur.mode[1:0] == word.tick_source);

    always_comb
    begin
        nxt = cur;
        if (word.action == udpic_pkg::ACT_TICK)
        begin
            if (hit)
            begin
                case (cur.mode[7:6])
                    udpic_pkg::DIR_UP:
                    begin
                        nxt.prescale = pre_up;
                        if ((pre_up & mask) == udpic_pkg::COUNT_ZERO)
                        begin
                            nxt.count = cnt_up;
                            if (cnt_up == udpic_pkg::COUNT_ZERO)
                            begin
                                nxt.pending = 1'b1;
                            end
                        end
                    end
                    udpic_pkg::DIR_DOWN:
                    begin
                        nxt.prescale = pre_down;
                        if ((pre_down & mask) == mask)
                        begin
                            nxt.count = cur.count - 8'd1;
                            // borrow out of zero raises the interrupt
                            if (cur.count == udpic_pkg::COUNT_ZERO)
                            begin
                                nxt.pending = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        nxt = cur;
                    end
                endcase
            end
        end
        else
        begin
            case (word.reg_index)
                udpic_pkg::REG_ENABLE_BIT:
                begin
                    nxt.enabled = word.write_data[0];
                    if (!word.write_data[0])
                    begin
                        nxt.pending = 1'b0;
                    end
                end
                udpic_pkg::REG_MODE:
                begin
                    nxt.mode = word.write_data;
                end
                udpic_pkg::REG_DISABLE:
                begin
                    nxt.enabled = 1'b0;
                    nxt.pending = 1'b0;
                end
                udpic_pkg::REG_ENABLE:
                begin
                    nxt.enabled = 1'b1;
                end
                udpic_pkg::REG_PRESCALE:
                begin
                    nxt.prescale = word.write_data ^ cur.flip;
                end
                udpic_pkg::REG_COUNT:
                begin
                    nxt.count = word.write_data ^ cur.flip;
                end
                udpic_pkg::REG_FLIP:
                begin
                    nxt.flip = word.write_data;
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

endmodule

// ===== hdl/up_down_prescaled_irq_counter_unit.sv =====
// up_down_prescaled_irq_counter_unit: a taken input word waits in the input register until
// out_stall lets it advance, then its state update is registered and out_valid rises
// one word per cycle unless stalled: input register, then state update and result register
// in_stall only rises when the input register is full and the result register is stalled
// rst_n asynchronous active low clears counter state with its enable and pending flags, and both valid bits
// depends on udpic_pkg and udpic_step

module up_down_prescaled_irq_counter_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [2:0] reg_index,
    input  logic [7:0] write_data,
    input  logic [1:0] tick_source,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       irq_pending,
    output logic [7:0] count_value,
    output logic [7:0] prescale_value
);

    logic                    in_valid_reg;
    udpic_pkg::udpic_word_t  word_reg;
    udpic_pkg::udpic_state_t state_reg;
    udpic_pkg::udpic_state_t state_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    irq_reg;
    logic [7:0]              count_out_reg;
    logic [7:0]              prescale_out_reg;
    logic                    advance;
    logic                    in_load;

    // input word moves on when the result register is empty or being taken
    assign advance        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_valid_reg && !advance;
    assign in_load        = !in_stall;
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    udpic_step u_step
    (
        .word (word_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            word_reg.action      <= action;
            word_reg.reg_index   <= reg_index;
            word_reg.write_data  <= write_data;
            word_reg.tick_source <= tick_source;
        end
        if (advance)
        begin
            irq_reg          <= state_next.pending;
            count_out_reg    <= state_next.count;
            prescale_out_reg <= state_next.prescale;
        end
    end

    assign out_valid      = out_valid_reg;
    assign irq_pending    = irq_reg;
    assign count_value    = count_out_reg;
    assign prescale_value = prescale_out_reg;

endmodule

// ===== hdl/udpic_checker.sv =====
// udpic_checker: port-level assertions for up_down_prescaled_irq_counter_unit
// bound to the top level below; depends on nothing else

module udpic_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       action,
    input logic [2:0] reg_index,
    input logic [7:0] write_data,
    input logic [1:0] tick_source,
    input logic       out_valid,
    input logic       out_stall,
    input logic       irq_pending,
    input logic [7:0] count_value,
    input logic [7:0] prescale_value
);

    logic       last_irq_reg;
    logic       out_take;

    assign out_take = out_valid && !out_stall;

    // irq of the previously delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_irq_reg <= 1'b0;
        end
        else if (out_take)
        begin
            last_irq_reg <= irq_pending;
        end
    end

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(irq_pending)
            && $stable(count_value) && $stable(prescale_value))
        else $error("stalled result word changed");

    // input only backs up when the output side is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output side free");

    // interrupt rises only on a count rollover to 0x00 or 0xff
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && irq_pending && !last_irq_reg
            |-> count_value == 8'h00 || count_value == 8'hFF)
        else $error("interrupt raised without count rollover");

    // interrupt rises only on a prescaler boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && irq_pending && !last_irq_reg
            |-> prescale_value[2:0] == 3'b000 || prescale_value[2:0] == 3'b111)
        else $error("interrupt raised off a prescaler boundary");

    // stalled input word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(action) && $stable(reg_index)
            && $stable(write_data) && $stable(tick_source))
        else $error("stalled input word changed");

endmodule

bind up_down_prescaled_irq_counter_unit udpic_checker u_udpic_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .reg_index      (reg_index),
    .write_data     (write_data),
    .tick_source    (tick_source),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .irq_pending    (irq_pending),
    .count_value    (count_value),
    .prescale_value (prescale_value)
);

// ===== tb/tb.sv =====
// tb: self-checking bench for up_down_prescaled_irq_counter_unit, directed table then random
// count bursts and noise words, checked word by word against table values or a predictor of the counter state
// depends on udpic_pkg and the counter unit

module tb;

    // register index with no register behind it
    localparam logic [2:0] REG_NONE = 3'd7;

    // tick sources
    localparam logic [1:0] SRC_CPU_CLK   = 2'd0;
    localparam logic [1:0] SRC_A12_RISE  = 2'd1;
    localparam logic [1:0] SRC_PPU_READ  = 2'd2;
    localparam logic [1:0] SRC_CPU_WRITE = 2'd3;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_WORDS = 620;

    typedef struct packed {
        logic       irq;
        logic [7:0] count;
        logic [7:0] prescale;
    } counter_view_t;

    typedef struct packed {
        logic       act;
        logic [2:0] idx;
        logic [7:0] data;
        logic [1:0] src;
        logic       typed;
        logic       irq;
        logic [7:0] count;
        logic [7:0] prescale;
    } stim_row_t;

    // rows with typed = 0 are checked against the predictor only
    localparam stim_row_t DIRECTED_ROWS [27] = '{
        '{udpic_pkg::ACT_TICK,  udpic_pkg::REG_ENABLE_BIT, 8'h00, SRC_CPU_CLK,
          1'b1, 1'b0, 8'h00, 8'h00},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_MODE,       8'h40, SRC_CPU_CLK,
          1'b1, 1'b0, 8'h00, 8'h00},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_ENABLE,     8'h00, SRC_CPU_CLK,
          1'b1, 1'b0, 8'h00, 8'h00},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_COUNT,      8'hFF, SRC_CPU_CLK,
          1'b1, 1'b0, 8'hFF, 8'h00},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_PRESCALE,   8'hFF, SRC_CPU_CLK,
          1'b1, 1'b0, 8'hFF, 8'hFF},
        '{udpic_pkg::ACT_TICK,  udpic_pkg::REG_ENABLE_BIT, 8'h00, SRC_CPU_CLK,
          1'b1, 1'b1, 8'h00, 8'h00},
        '{udpic_pkg::ACT_TICK,  udpic_pkg::REG_ENABLE_BIT, 8'h00, SRC_A12_RISE,
          1'b1, 1'b1, 8'h00, 8'h00},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_ENABLE_BIT, 8'h01, SRC_CPU_CLK,
          1'b1, 1'b1, 8'h00, 8'h00},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_ENABLE_BIT, 8'hFE, SRC_CPU_CLK,
          1'b1, 1'b0, 8'h00, 8'h00},
        '{udpic_pkg::ACT_TICK,  udpic_pkg::REG_ENABLE_BIT, 8'h00, SRC_CPU_CLK,
          1'b1, 1'b0, 8'h00, 8'h00},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_ENABLE,     8'h00, SRC_CPU_CLK,
          1'b1, 1'b0, 8'h00, 8'h00},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_MODE,       8'h87, SRC_CPU_CLK,
          1'b1, 1'b0, 8'h00, 8'h00},
        '{udpic_pkg::ACT_TICK,  udpic_pkg::REG_ENABLE_BIT, 8'h00, SRC_CPU_WRITE,
          1'b1, 1'b1, 8'hFF, 8'hFF},
        '{udpic_pkg::ACT_TICK,  udpic_pkg::REG_ENABLE_BIT, 8'h00, SRC_CPU_WRITE,
          1'b0, 1'b0, 8'h00, 8'h00},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_DISABLE,    8'h00, SRC_CPU_CLK,
          1'b1, 1'b0, 8'hFF, 8'hFE},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_ENABLE,     8'hFF, SRC_CPU_CLK,
          1'b1, 1'b0, 8'hFF, 8'hFE},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_MODE,       8'hC3, SRC_CPU_CLK,
          1'b1, 1'b0, 8'hFF, 8'hFE},
        '{udpic_pkg::ACT_TICK,  udpic_pkg::REG_ENABLE_BIT, 8'h00, SRC_CPU_WRITE,
          1'b1, 1'b0, 8'hFF, 8'hFE},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_MODE,       8'h03, SRC_CPU_CLK,
          1'b1, 1'b0, 8'hFF, 8'hFE},
        '{udpic_pkg::ACT_TICK,  udpic_pkg::REG_ENABLE_BIT, 8'h00, SRC_CPU_WRITE,
          1'b1, 1'b0, 8'hFF, 8'hFE},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_FLIP,       8'hA5, SRC_CPU_CLK,
          1'b1, 1'b0, 8'hFF, 8'hFE},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_COUNT,      8'h5A, SRC_CPU_CLK,
          1'b1, 1'b0, 8'hFF, 8'hFE},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_PRESCALE,   8'h00, SRC_CPU_CLK,
          1'b1, 1'b0, 8'hFF, 8'hA5},
        '{udpic_pkg::ACT_WRITE, REG_NONE,                  8'hFF, SRC_CPU_CLK,
          1'b1, 1'b0, 8'hFF, 8'hA5},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_MODE,       8'h46, SRC_CPU_CLK,
          1'b1, 1'b0, 8'hFF, 8'hA5},
        '{udpic_pkg::ACT_TICK,  udpic_pkg::REG_ENABLE_BIT, 8'h00, SRC_PPU_READ,
          1'b0, 1'b0, 8'h00, 8'h00},
        '{udpic_pkg::ACT_WRITE, udpic_pkg::REG_FLIP,       8'h00, SRC_CPU_CLK,
          1'b1, 1'b0, 8'hFF, 8'hA6}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       action;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [1:0] tick_source;
    logic       out_valid;
    logic       out_stall;
    logic       irq_pending;
    logic [7:0] count_value;
    logic [7:0] prescale_value;

    // predicted counter state
    logic       ctr_enabled;
    logic [7:0] ctr_mode;
    logic [7:0] ctr_prescale;
    logic [7:0] ctr_count;
    logic [7:0] ctr_flip;
    logic       ctr_irq;

    counter_view_t predicted_q[$];
    int            error_count;
    int            counted_words;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            quiet_cycles;

    up_down_prescaled_irq_counter_unit u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .reg_index      (reg_index),
        .write_data     (write_data),
        .tick_source    (tick_source),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .irq_pending    (irq_pending),
        .count_value    (count_value),
        .prescale_value (prescale_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // steps the predicted counter state by one word
    function automatic void advance_counter(input logic act, input logic [2:0] idx,
                                            input logic [7:0] data, input logic [1:0] src);
        logic [7:0] mask;
        mask = ctr_mode[2] ? udpic_pkg::SCALE_NARROW : udpic_pkg::SCALE_WIDE;
        if (act == udpic_pkg::ACT_WRITE)
        begin
            case (idx)
                udpic_pkg::REG_ENABLE_BIT:
                begin
                    ctr_enabled = data[0];
                    if (!data[0])
                        ctr_irq = 1'b0;
                end
                udpic_pkg::REG_MODE:     ctr_mode = data;
                udpic_pkg::REG_DISABLE:
                begin
                    ctr_enabled = 1'b0;
                    ctr_irq     = 1'b0;
                end
                udpic_pkg::REG_ENABLE:   ctr_enabled = 1'b1;
                udpic_pkg::REG_PRESCALE: ctr_prescale = data ^ ctr_flip;
                udpic_pkg::REG_COUNT:    ctr_count = data ^ ctr_flip;
                udpic_pkg::REG_FLIP:     ctr_flip = data;
                default:                 return;
            endcase
            return;
        end
        if (!ctr_enabled || ctr_mode[1:0] != src)
            return;
        if (ctr_mode[7:6] == udpic_pkg::DIR_DOWN)
        begin
            ctr_prescale = ctr_prescale - 8'd1;
            if ((ctr_prescale & mask) == mask)
            begin
                // borrow out of zero raises the interrupt
                if (ctr_count == udpic_pkg::COUNT_ZERO)
                    ctr_irq = 1'b1;
                ctr_count = ctr_count - 8'd1;
            end
            return;
        end
        if (ctr_mode[7:6] == udpic_pkg::DIR_UP)
        begin
            ctr_prescale = ctr_prescale + 8'd1;
            if ((ctr_prescale & mask) == udpic_pkg::COUNT_ZERO)
            begin
                ctr_count = ctr_count + 8'd1;
                if (ctr_count == udpic_pkg::COUNT_ZERO)
                    ctr_irq = 1'b1;
            end
        end
    endfunction

    // valid stays high from one word to the next unless the sender idles
    task automatic send_word(input logic act, input logic [2:0] idx, input logic [7:0] data,
                             input logic [1:0] src, input bit use_typed,
                             input counter_view_t typed_view);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        reg_index   <= idx;
        write_data  <= data;
        tick_source <= src;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_counter(act, idx, data, src);
        if (use_typed)
            predicted_q.push_back(typed_view);
        else
            predicted_q.push_back('{ctr_irq, ctr_count, ctr_prescale});
    endtask

    task automatic drive_word(input logic act, input logic [2:0] idx, input logic [7:0] data,
                              input logic [1:0] src);
        send_word(act, idx, data, src, 1'b0, '0);
        counted_words++;
    endtask

    task automatic drive_noise();
        drive_word(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom_range(255)),
                   2'($urandom_range(3)));
    endtask

    // optionally disable, program flip, count, prescaler and mode, enable, then a run of ticks with noise
    task automatic run_count_burst();
        logic [7:0] mode_w;
        logic [7:0] flip_w;
        logic [7:0] start_count;
        logic [7:0] start_prescale;
        logic [1:0] src_sel;
        int         n_ticks;
        flip_w  = 8'($urandom_range(255));
        src_sel = 2'($urandom_range(3));
        mode_w  = 8'($urandom_range(255));
        mode_w[7:6] = $urandom_range(1) ? udpic_pkg::DIR_UP : udpic_pkg::DIR_DOWN;
        mode_w[1:0] = src_sel;
        case ($urandom_range(4))
            0:       start_count = 8'h00;
            1:       start_count = 8'h01;
            2:       start_count = 8'hFF;
            3:       start_count = 8'hFE;
            default: start_count = 8'($urandom_range(255));
        endcase
        // in wide mode start near the rollover so the count gets to move
        if (!mode_w[2] && $urandom_range(3) != 0)
            start_prescale = (mode_w[7:6] == udpic_pkg::DIR_UP)
                             ? 8'($urandom_range(232, 255))
                             : 8'($urandom_range(0, 23));
        else
            start_prescale = 8'($urandom_range(255));
        if ($urandom_range(3) == 0)
            drive_word(udpic_pkg::ACT_WRITE, udpic_pkg::REG_DISABLE, 8'($urandom_range(255)),
                       2'($urandom_range(3)));
        drive_word(udpic_pkg::ACT_WRITE, udpic_pkg::REG_FLIP, flip_w, 2'($urandom_range(3)));
        drive_word(udpic_pkg::ACT_WRITE, udpic_pkg::REG_COUNT, start_count ^ flip_w,
                   2'($urandom_range(3)));
        drive_word(udpic_pkg::ACT_WRITE, udpic_pkg::REG_PRESCALE, start_prescale ^ flip_w,
                   2'($urandom_range(3)));
        drive_word(udpic_pkg::ACT_WRITE, udpic_pkg::REG_MODE, mode_w, 2'($urandom_range(3)));
        if ($urandom_range(1))
            drive_word(udpic_pkg::ACT_WRITE, udpic_pkg::REG_ENABLE, 8'($urandom_range(255)),
                       2'($urandom_range(3)));
        else
            drive_word(udpic_pkg::ACT_WRITE, udpic_pkg::REG_ENABLE_BIT,
                       8'($urandom_range(255)) | 8'h01, 2'($urandom_range(3)));
        n_ticks = $urandom_range(4, 48);
        repeat (n_ticks)
        begin
            if ($urandom_range(11) == 0)
                drive_noise();
            else
                drive_word(udpic_pkg::ACT_TICK, 3'($urandom_range(7)),
                           8'($urandom_range(255)), src_sel);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_q.size() != 0);
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        counter_view_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_q.size() == 0)
            begin
                report_mismatch("unexpected word", count_value, 0);
            end
            else
            begin
                want = predicted_q.pop_front();
                if (irq_pending !== want.irq)
                    report_mismatch("irq_pending", irq_pending, want.irq);
                if (count_value !== want.count)
                    report_mismatch("count_value", count_value, want.count);
                if (prescale_value !== want.prescale)
                    report_mismatch("prescale_value", prescale_value, want.prescale);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        int        phase_end;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        action         <= udpic_pkg::ACT_WRITE;
        reg_index      <= udpic_pkg::REG_ENABLE_BIT;
        write_data     <= 8'h00;
        tick_source    <= SRC_CPU_CLK;
        out_stall      <= 1'b0;
        quiet_cycles   <= 0;
        error_count    = 0;
        counted_words  = 0;
        send_idle_pct  = 21;
        recv_stall_pct = 71;
        ctr_enabled    = 1'b0;
        ctr_mode       = 8'h00;
        ctr_prescale   = 8'h00;
        ctr_count      = 8'h00;
        ctr_flip       = 8'h00;
        ctr_irq        = 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            row = DIRECTED_ROWS[i];
            send_word(row.act, row.idx, row.data, row.src, row.typed,
                      '{row.irq, row.count, row.prescale});
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            // sender holds off until the pipeline is empty before each phase
            drain_results();
            case (phase)
                0:
                begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 71;
                end
                1:
                begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 21;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            phase_end = counted_words + PHASE_WORDS;
            while (counted_words < phase_end)
            begin
                if ($urandom_range(9) < 8)
                    run_count_burst();
                else
                    repeat ($urandom_range(1, 5))
                        drive_noise();
            end
        end

        drain_results();
        repeat (6)
            @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/udpic_pkg.sv
hdl/udpic_step.sv
hdl/up_down_prescaled_irq_counter_unit.sv
hdl/udpic_checker.sv
tb/tb.sv
